>>> rtl/region_scan_position_generator_top_assert.svh
`ifndef REGION_SCAN_POSITION_GENERATOR_TOP_ASSERT_SVH
`define REGION_SCAN_POSITION_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSPG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rspg: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rspg: next-cycle check failed");

`endif

>>> rtl/rspg_pkg.sv
package rspg_pkg;

	localparam int RADIUS_BITS    = 12;
	localparam int KIND_BITS      = 2;
	localparam int CFG_INDEX_BITS = 1;
	localparam int WORLD_RESET    = 256;

	localparam logic [KIND_BITS-1:0] KIND_CELL   = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_RECT   = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_CIRCLE = 2'd2;
	localparam logic [KIND_BITS-1:0] KIND_WORLD  = 2'd3;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_NEXT  = 1'b1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_WORLD_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WORLD_HEIGHT = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic req_ready;
		logic capture;
		logic start_clear;
		logic emit_cell;
		logic load_box;
		logic begin_scan;
		logic resume;
		logic row_wrap;
		logic step_x;
		logic square;
		logic stop_scan;
		logic emit_found;
		logic emit_none;
		logic out_load;
	} rspg_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic                 req_valid;
		logic                 req_mode;
		logic [KIND_BITS-1:0] req_kind;
		logic                 world_empty;
		logic                 cell_inside;
		logic                 radius_zero;
		logic                 box_empty;
		logic                 scan_active;
		logic [KIND_BITS-1:0] held_kind;
		logic                 cand_x_over;
		logic                 cand_y_over;
		logic                 masked;
		logic                 out_free;
	} rspg_stat_t;

endpackage

>>> rtl/rspg_if.sv
interface rspg_req_if #(parameter int COORD_BITS = 16) ();
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic [rspg_pkg::KIND_BITS-1:0]   range_kind;
	logic [COORD_BITS-1:0]            first_x;
	logic [COORD_BITS-1:0]            first_y;
	logic [COORD_BITS-1:0]            second_x;
	logic [COORD_BITS-1:0]            second_y;
	logic [rspg_pkg::RADIUS_BITS-1:0] radius_q;

	modport source (
		output valid, mode, range_kind, first_x, first_y, second_x, second_y, radius_q,
		input  ready
	);
	modport sink (
		input  valid, mode, range_kind, first_x, first_y, second_x, second_y, radius_q,
		output ready
	);
endinterface

interface rspg_rsp_if #(parameter int COORD_BITS = 16) ();
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;

	modport source (output valid, found, pos_x, pos_y, input ready);
	modport sink (input valid, found, pos_x, pos_y, output ready);
endinterface

>>> rtl/rspg_ctrl.sv
module rspg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rspg_pkg::rspg_stat_t stat,
	output rspg_pkg::rspg_cmd_t  cmd
);
	import rspg_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_BOXCHK = 6'b000100,
		ST_CHECK  = 6'b001000,
		ST_TEST   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.req_ready = 1'b1;
				if (stat.req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.req_mode == MODE_START) begin
					cmd.start_clear = 1'b1;
					if (stat.world_empty) begin
						cmd.emit_none = 1'b1;
						state_d       = ST_DONE;
					end else if (stat.req_kind == KIND_CELL) begin
						cmd.emit_cell = stat.cell_inside;
						cmd.emit_none = !stat.cell_inside;
						state_d       = ST_DONE;
					end else if (stat.req_kind == KIND_CIRCLE && stat.radius_zero) begin
						cmd.emit_none = 1'b1;
						state_d       = ST_DONE;
					end else begin
						cmd.load_box = 1'b1;
						state_d      = ST_BOXCHK;
					end
				end else if (!stat.scan_active || stat.held_kind == KIND_CELL) begin
					cmd.emit_none = 1'b1;
					state_d       = ST_DONE;
				end else begin
					cmd.resume = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_BOXCHK: begin
				if (stat.box_empty) begin
					cmd.emit_none = 1'b1;
					state_d       = ST_DONE;
				end else begin
					cmd.begin_scan = 1'b1;
					state_d        = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.cand_y_over) begin
					cmd.stop_scan = 1'b1;
					cmd.emit_none = 1'b1;
					state_d       = ST_DONE;
				end else if (stat.cand_x_over) begin
					cmd.row_wrap = 1'b1;
				end else if (stat.held_kind != KIND_CIRCLE) begin
					cmd.emit_found = 1'b1;
					state_d        = ST_DONE;
				end else begin
					cmd.square = 1'b1;
					state_d    = ST_TEST;
				end
			end
			ST_TEST: begin
				if (stat.masked) begin
					cmd.step_x = 1'b1;
					state_d    = ST_CHECK;
				end else begin
					cmd.emit_found = 1'b1;
					state_d        = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/rspg_datapath.sv
module rspg_datapath #(
	parameter int COORD_BITS       = 16,
	parameter int RADIUS_FRAC_BITS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	rspg_req_if.sink                            req,
	rspg_rsp_if.source                          rsp,
	input  logic                                cfg_we,
	input  logic [rspg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	input  rspg_pkg::rspg_cmd_t                 cmd,
	output rspg_pkg::rspg_stat_t                stat
);
	import rspg_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int F   = RADIUS_FRAC_BITS;
	localparam int BW  = ((CB + F > RADIUS_BITS) ? CB + F : RADIUS_BITS) + 2;
	localparam int DW0 = 2 * CB + 1 + 2 * F;
	localparam int DW  = (DW0 > 2 * RADIUS_BITS) ? DW0 : 2 * RADIUS_BITS;
	localparam logic [BW-1:0] HALF = BW'((1 << F) >> 1);
	localparam logic [CB-1:0] WORLD_INIT = (CB >= 9) ? CB'(WORLD_RESET) : {CB{1'b1}};

	// captured request
	logic                   req_mode_q;
	logic [KIND_BITS-1:0]   req_kind_q;
	logic [CB-1:0]          req_fx_q, req_fy_q, req_sx_q, req_sy_q;
	logic [RADIUS_BITS-1:0] req_rq_q;

	// scan state
	logic [CB-1:0]          world_w_q, world_h_q;
	logic [CB-1:0]          low_x_q, low_y_q, high_x_q, high_y_q;
	logic [CB-1:0]          center_x_q, center_y_q;
	logic [2*RADIUS_BITS-1:0] rsq_q;
	logic [KIND_BITS-1:0]   kind_held_q;
	logic                   scan_active_q;
	logic [CB-1:0]          cursor_x_q, cursor_y_q;
	logic [CB:0]            cand_x_q, cand_y_q;
	logic [2*CB-1:0]        sq_x_q, sq_y_q;

	// result staging and output register
	logic                   res_found_q;
	logic [CB-1:0]          res_x_q, res_y_q;
	logic                   out_valid_q, out_found_q;
	logic [CB-1:0]          out_x_q, out_y_q;

	logic [CB-1:0]          wmx, wmy;
	logic [CB-1:0]          dx, dy;
	logic [BW-1:0]          fx_sh, fy_sh, rq_ext;
	logic [DW-1:0]          dist_sq;

	function automatic logic [CB-1:0] round_clamp(input logic [BW-1:0] num,
	                                              input logic [CB-1:0] lim);
		logic [BW-1:0] q;
		logic [CB-1:0] r;
		q = num >> F;
		if (num[BW-1]) begin
			r = '0;
		end else if (q > BW'(lim)) begin
			r = lim;
		end else begin
			r = q[CB-1:0];
		end
		return r;
	endfunction

	assign wmx    = world_w_q - CB'(1);
	assign wmy    = world_h_q - CB'(1);
	assign fx_sh  = BW'(req_fx_q) << F;
	assign fy_sh  = BW'(req_fy_q) << F;
	assign rq_ext = BW'(req_rq_q);

	assign dx = (cand_x_q[CB-1:0] >= center_x_q) ? cand_x_q[CB-1:0] - center_x_q
	                                             : center_x_q - cand_x_q[CB-1:0];
	assign dy = (cand_y_q[CB-1:0] >= center_y_q) ? cand_y_q[CB-1:0] - center_y_q
	                                             : center_y_q - cand_y_q[CB-1:0];
	assign dist_sq = (DW'(sq_x_q) + DW'(sq_y_q)) << (2 * F);

	assign stat.req_valid   = req.valid;
	assign stat.req_mode    = req_mode_q;
	assign stat.req_kind    = req_kind_q;
	assign stat.world_empty = (world_w_q == '0) || (world_h_q == '0);
	assign stat.cell_inside = (req_fx_q < world_w_q) && (req_fy_q < world_h_q);
	assign stat.radius_zero = (req_rq_q == '0);
	assign stat.box_empty   = (low_x_q > high_x_q) || (low_y_q > high_y_q);
	assign stat.scan_active = scan_active_q;
	assign stat.held_kind   = kind_held_q;
	assign stat.cand_x_over = cand_x_q > {1'b0, high_x_q};
	assign stat.cand_y_over = cand_y_q > {1'b0, high_y_q};
	assign stat.masked      = dist_sq > DW'(rsq_q);
	assign stat.out_free    = !out_valid_q || rsp.ready;

	assign req.ready = cmd.req_ready;
	assign rsp.valid = out_valid_q;
	assign rsp.found = out_found_q;
	assign rsp.pos_x = out_x_q;
	assign rsp.pos_y = out_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			world_w_q     <= WORLD_INIT;
			world_h_q     <= WORLD_INIT;
			kind_held_q   <= KIND_CELL;
			scan_active_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WORLD_WIDTH:  world_w_q <= cfg_data;
					REG_WORLD_HEIGHT: world_h_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.start_clear) begin
				kind_held_q   <= req_kind_q;
				scan_active_q <= 1'b0;
			end
			if (cmd.begin_scan) begin
				scan_active_q <= 1'b1;
			end
			if (cmd.stop_scan) begin
				scan_active_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_mode_q <= req.mode;
			req_kind_q <= req.range_kind;
			req_fx_q   <= req.first_x;
			req_fy_q   <= req.first_y;
			req_sx_q   <= req.second_x;
			req_sy_q   <= req.second_y;
			req_rq_q   <= req.radius_q;
		end
		if (cmd.load_box) begin
			case (req_kind_q)
				KIND_WORLD: begin
					low_x_q  <= '0;
					low_y_q  <= '0;
					high_x_q <= wmx;
					high_y_q <= wmy;
				end
				KIND_RECT: begin
					low_x_q  <= (req_fx_q < wmx) ? req_fx_q : wmx;
					low_y_q  <= (req_fy_q < wmy) ? req_fy_q : wmy;
					high_x_q <= (req_sx_q < wmx) ? req_sx_q : wmx;
					high_y_q <= (req_sy_q < wmy) ? req_sy_q : wmy;
				end
				default: begin
					center_x_q <= req_fx_q;
					center_y_q <= req_fy_q;
					rsq_q      <= {{RADIUS_BITS{1'b0}}, req_rq_q}
					              * {{RADIUS_BITS{1'b0}}, req_rq_q};
					low_x_q    <= round_clamp(fx_sh - rq_ext + HALF, wmx);
					low_y_q    <= round_clamp(fy_sh - rq_ext + HALF, wmy);
					high_x_q   <= round_clamp(fx_sh + rq_ext + HALF, wmx);
					high_y_q   <= round_clamp(fy_sh + rq_ext + HALF, wmy);
				end
			endcase
		end
		if (cmd.begin_scan) begin
			cand_x_q <= {1'b0, low_x_q};
			cand_y_q <= {1'b0, low_y_q};
		end else if (cmd.resume) begin
			cand_x_q <= {1'b0, cursor_x_q} + (CB+1)'(1);
			cand_y_q <= {1'b0, cursor_y_q};
		end else if (cmd.row_wrap) begin
			cand_x_q <= {1'b0, low_x_q};
			cand_y_q <= cand_y_q + (CB+1)'(1);
		end else if (cmd.step_x) begin
			cand_x_q <= cand_x_q + (CB+1)'(1);
		end
		if (cmd.square) begin
			sq_x_q <= {{CB{1'b0}}, dx} * {{CB{1'b0}}, dx};
			sq_y_q <= {{CB{1'b0}}, dy} * {{CB{1'b0}}, dy};
		end
		if (cmd.emit_cell) begin
			cursor_x_q  <= req_fx_q;
			cursor_y_q  <= req_fy_q;
			res_found_q <= 1'b1;
			res_x_q     <= req_fx_q;
			res_y_q     <= req_fy_q;
		end else if (cmd.emit_found) begin
			cursor_x_q  <= cand_x_q[CB-1:0];
			cursor_y_q  <= cand_y_q[CB-1:0];
			res_found_q <= 1'b1;
			res_x_q     <= cand_x_q[CB-1:0];
			res_y_q     <= cand_y_q[CB-1:0];
		end else if (cmd.emit_none) begin
			res_found_q <= 1'b0;
			res_x_q     <= '0;
			res_y_q     <= '0;
		end
		if (cmd.out_load) begin
			out_found_q <= res_found_q;
			out_x_q     <= res_x_q;
			out_y_q     <= res_y_q;
		end
	end

endmodule

>>> rtl/region_scan_position_generator_top.sv
// Region scan position generator: walks the cells of a region row by row.
// req channel: mode 0 starts a scan (range_kind, first_x/y, second_x/y,
// radius_q) and returns the first cell; mode 1 returns the next cell.
// rsp channel: exactly one response per request: found with pos_x/pos_y,
// or found 0 with a zero position once the region is empty or used up.
// Config port: cfg_we writes world width (index 0) or height (index 1);
// write only while no request is in flight.
// Decode alone answers a single cell, an empty world, a zero radius and a
// next with no scan. A start that walks the box loads and checks the box
// first (an empty box is answered there); a next resumes the walk, and
// each row wrap takes a check step of its own. A circle cell passes one
// square stage and one compare stage, so each masked cell skipped adds both.
// One request is worked on at a time; the next one is taken the cycle
// after the previous response is loaded.
// Reset clears the scan, sets the world to 256 x 256 and empties the
// output register. When rsp is stalled the response holds and the block
// still accepts one more request, finishing it into a staging register.
`include "region_scan_position_generator_top_assert.svh"

module region_scan_position_generator_top #(
	parameter int COORD_BITS       = 16,
	parameter int RADIUS_FRAC_BITS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	rspg_req_if.sink                            req,
	rspg_rsp_if.source                          rsp,
	input  logic                                cfg_we,
	input  logic [rspg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data
);
	import rspg_pkg::*;

	rspg_cmd_t  cmd;
	rspg_stat_t stat;

	rspg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	rspg_datapath #(
		.COORD_BITS       (COORD_BITS),
		.RADIUS_FRAC_BITS (RADIUS_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	`RSPG_ASSERT_NEXT(a_one_request, clk, arst_n, req.valid && req.ready, !req.ready)
	`RSPG_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.out_load, stat.out_free)
	`RSPG_ASSERT_NOW(a_emit_in_box, clk, arst_n, cmd.emit_found, !stat.cand_x_over && !stat.cand_y_over)
	`RSPG_ASSERT_NOW(a_empty_zero, clk, arst_n, rsp.valid && !rsp.found, rsp.pos_x == '0 && rsp.pos_y == '0)

endmodule

>>> test/tb.sv
module tb;
	import rspg_pkg::*;

	localparam int COORD_W = 16;
	localparam int FRAC = 4;
	localparam int HOLD_CYCLES = 400;
	localparam longint LIMIT_TIME = 40_000_000;

	typedef struct {
		logic                   mode;
		logic [KIND_BITS-1:0]   kind;
		logic [COORD_W-1:0]     fx;
		logic [COORD_W-1:0]     fy;
		logic [COORD_W-1:0]     sx;
		logic [COORD_W-1:0]     sy;
		logic [RADIUS_BITS-1:0] rq;
	} scan_req_t;

	typedef struct {
		logic               found;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} pos_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [COORD_W-1:0] cfg_data;

	rspg_req_if #(.COORD_BITS(COORD_W)) req_ch ();
	rspg_rsp_if #(.COORD_BITS(COORD_W)) rsp_ch ();

	region_scan_position_generator_top #(
		.COORD_BITS(COORD_W),
		.RADIUS_FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	scan_req_t pending_reqs[$];
	pos_t expected_pos[$];
	scan_req_t taken;
	pos_t want;
	int errors = 0;
	int unsigned idle_pct;
	int unsigned stall_pct;
	logic hold_arm;
	logic hold_used;
	int unsigned hold_left;

	// scan state mirrored from the block
	int unsigned wld_w = WORLD_RESET;
	int unsigned wld_h = WORLD_RESET;
	longint unsigned cur_x = 0, cur_y = 0;
	longint unsigned lo_x = 0, lo_y = 0, hi_x = 0, hi_y = 0;
	longint unsigned ctr_x = 0, ctr_y = 0, rad = 0;
	logic [KIND_BITS-1:0] held_kind = KIND_CELL;
	bit walking = 0;

	function automatic longint unsigned umin(longint unsigned a, longint unsigned b);
		return a < b ? a : b;
	endfunction

	function automatic longint unsigned round_edge(longint num);
		num = num + ((1 << FRAC) >> 1);
		if (num < 0)
			return 0;
		return longint'(num) >> FRAC;
	endfunction

	function automatic bit outside_circle(longint unsigned x, longint unsigned y);
		longint unsigned dx, dy, dsq;
		if (held_kind != KIND_CIRCLE)
			return 1'b0;
		dx = x > ctr_x ? x - ctr_x : ctr_x - x;
		dy = y > ctr_y ? y - ctr_y : ctr_y - y;
		dsq = (dx * dx + dy * dy) << (2 * FRAC);
		return dsq > rad * rad;
	endfunction

	// row-major search from (x, y) inclusive; ends the scan when nothing is left
	function automatic pos_t walk_from(longint unsigned x, longint unsigned y);
		pos_t res;
		res = '{found: 1'b0, x: '0, y: '0};
		while (y <= hi_y) begin
			while (x <= hi_x) begin
				if (!outside_circle(x, y)) begin
					cur_x = x;
					cur_y = y;
					res.found = 1'b1;
					res.x = x[COORD_W-1:0];
					res.y = y[COORD_W-1:0];
					return res;
				end
				x++;
			end
			x = lo_x;
			y++;
		end
		walking = 0;
		return res;
	endfunction

	function automatic pos_t region_step(scan_req_t r);
		pos_t res;
		longint unsigned wx, wy;
		longint cx, cy;
		res = '{found: 1'b0, x: '0, y: '0};
		if (r.mode == MODE_NEXT) begin
			if (!walking || held_kind == KIND_CELL)
				return res;
			return walk_from(cur_x + 1, cur_y);
		end
		walking = 0;
		held_kind = r.kind;
		if (wld_w == 0 || wld_h == 0)
			return res;
		wx = 64'(wld_w - 1);
		wy = 64'(wld_h - 1);
		case (r.kind)
			KIND_CELL: begin
				if (r.fx < wld_w && r.fy < wld_h) begin
					cur_x = 64'(r.fx);
					cur_y = 64'(r.fy);
					res.found = 1'b1;
					res.x = r.fx;
					res.y = r.fy;
				end
				return res;
			end
			KIND_WORLD: begin
				lo_x = 0;
				lo_y = 0;
				hi_x = wx;
				hi_y = wy;
			end
			KIND_RECT: begin
				lo_x = umin(64'(r.fx), wx);
				lo_y = umin(64'(r.fy), wy);
				hi_x = umin(64'(r.sx), wx);
				hi_y = umin(64'(r.sy), wy);
			end
			default: begin
				if (r.rq == 0)
					return res;
				ctr_x = 64'(r.fx);
				ctr_y = 64'(r.fy);
				rad = 64'(r.rq);
				cx = longint'(r.fx) << FRAC;
				cy = longint'(r.fy) << FRAC;
				lo_x = umin(round_edge(cx - longint'(r.rq)), wx);
				lo_y = umin(round_edge(cy - longint'(r.rq)), wy);
				hi_x = umin(round_edge(cx + longint'(r.rq)), wx);
				hi_y = umin(round_edge(cy + longint'(r.rq)), wy);
			end
		endcase
		if (lo_x > hi_x || lo_y > hi_y)
			return res;
		walking = 1;
		return walk_from(lo_x, lo_y);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				taken = pending_reqs.pop_front();
				expected_pos.push_back(region_step(taken));
			end
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
					req_ch.valid <= 1'b1;
					req_ch.mode <= pending_reqs[0].mode;
					req_ch.range_kind <= pending_reqs[0].kind;
					req_ch.first_x <= pending_reqs[0].fx;
					req_ch.first_y <= pending_reqs[0].fy;
					req_ch.second_x <= pending_reqs[0].sx;
					req_ch.second_y <= pending_reqs[0].sy;
					req_ch.radius_q <= pending_reqs[0].rq;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, fired once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_arm && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_pos.size() == 0) begin
					$display("%0t: unexpected response found %0b pos (%0d,%0d)", $time,
						rsp_ch.found, rsp_ch.pos_x, rsp_ch.pos_y);
					errors++;
				end else begin
					want = expected_pos.pop_front();
					if (rsp_ch.found !== want.found) begin
						$display("%0t: found expected %0b actual %0b", $time,
							want.found, rsp_ch.found);
						errors++;
					end
					if (rsp_ch.pos_x !== want.x) begin
						$display("%0t: pos_x expected %0d actual %0d", $time,
							want.x, rsp_ch.pos_x);
						errors++;
					end
					if (rsp_ch.pos_y !== want.y) begin
						$display("%0t: pos_y expected %0d actual %0d", $time,
							want.y, rsp_ch.pos_y);
						errors++;
					end
				end
			end
			rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic scan_req_t start_req(logic [KIND_BITS-1:0] kind, int unsigned fx,
			int unsigned fy, int unsigned sx, int unsigned sy, int unsigned rq);
		scan_req_t r;
		r.mode = MODE_START;
		r.kind = kind;
		r.fx = COORD_W'(fx);
		r.fy = COORD_W'(fy);
		r.sx = COORD_W'(sx);
		r.sy = COORD_W'(sy);
		r.rq = RADIUS_BITS'(rq);
		return r;
	endfunction

	// fields other than mode are don't-care on a next request
	function automatic scan_req_t next_req();
		scan_req_t r;
		r.mode = MODE_NEXT;
		r.kind = KIND_BITS'($urandom_range(3));
		r.fx = COORD_W'($urandom);
		r.fy = COORD_W'($urandom);
		r.sx = COORD_W'($urandom);
		r.sy = COORD_W'($urandom);
		r.rq = RADIUS_BITS'($urandom);
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(int unsigned lim);
		case ($urandom_range(9))
			0: return COORD_W'($urandom);
			1: return '0;
			2: return '1;
			default: return COORD_W'($urandom_range(lim + 2 > 65535 ? 65535 : lim + 2));
		endcase
	endfunction

	function automatic logic [RADIUS_BITS-1:0] pick_radius();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return RADIUS_BITS'($urandom_range(4095));
			default: return RADIUS_BITS'($urandom_range(1, 80));
		endcase
	endfunction

	// one start with a run of next requests, or a little noise; returns requests added
	function automatic int add_random_scan();
		scan_req_t r;
		int n;
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(1, 3);
			repeat (n) pending_reqs.push_back(next_req());
			return n;
		end
		r = start_req(KIND_BITS'($urandom_range(3)), pick_coord(wld_w), pick_coord(wld_h),
			0, 0, pick_radius());
		if ($urandom_range(3) == 0) begin
			r.sx = pick_coord(wld_w);
			r.sy = pick_coord(wld_h);
		end else begin
			r.sx = r.fx + COORD_W'($urandom_range(6));
			r.sy = r.fy + COORD_W'($urandom_range(6));
		end
		pending_reqs.push_back(r);
		n = ($urandom_range(4) == 0) ? $urandom_range(40) : $urandom_range(8);
		repeat (n) pending_reqs.push_back(next_req());
		return n + 1;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_pos.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= COORD_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WORLD_WIDTH)
			wld_w = val;
		else
			wld_h = val;
	endtask

	task automatic run_phase(int unsigned w, int unsigned h, int n, int unsigned sidle,
			int unsigned rstall, bit squeeze);
		int added;
		wait_drained();
		write_reg(REG_WORLD_WIDTH, w);
		write_reg(REG_WORLD_HEIGHT, h);
		@(posedge clk);
		idle_pct <= sidle;
		stall_pct <= rstall;
		if (squeeze)
			hold_arm <= 1'b1;
		@(negedge clk);
		added = 0;
		while (added < n)
			added += add_random_scan();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WORLD_WIDTH;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_arm = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_START;
		req_ch.range_kind = KIND_CELL;
		req_ch.first_x = '0;
		req_ch.first_y = '0;
		req_ch.second_x = '0;
		req_ch.second_y = '0;
		req_ch.radius_q = '0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset world 256 x 256
		pending_reqs.push_back(next_req());
		pending_reqs.push_back(start_req(KIND_CELL, 0, 0, 9, 9, 5));
		pending_reqs.push_back(next_req());
		pending_reqs.push_back(start_req(KIND_CELL, 255, 255, 0, 0, 0));
		pending_reqs.push_back(start_req(KIND_CELL, 256, 0, 0, 0, 0));
		pending_reqs.push_back(start_req(KIND_CELL, 65535, 65535, 65535, 65535, 4095));
		pending_reqs.push_back(start_req(KIND_RECT, 2, 3, 4, 3, 0));
		repeat (4) pending_reqs.push_back(next_req());
		// min corner past max corner
		pending_reqs.push_back(start_req(KIND_RECT, 5, 0, 4, 9, 0));
		pending_reqs.push_back(start_req(KIND_RECT, 254, 255, 65535, 65535, 0));
		pending_reqs.push_back(next_req());
		pending_reqs.push_back(start_req(KIND_CIRCLE, 10, 10, 0, 0, 0));
		pending_reqs.push_back(next_req());
		pending_reqs.push_back(start_req(KIND_CIRCLE, 0, 0, 0, 0, 24));
		repeat (2) pending_reqs.push_back(next_req());
		// rectangle right after a circle must not be masked
		pending_reqs.push_back(start_req(KIND_RECT, 100, 100, 101, 100, 0));
		pending_reqs.push_back(start_req(KIND_CIRCLE, 65535, 65535, 0, 0, 4095));
		pending_reqs.push_back(start_req(KIND_WORLD, 7, 7, 7, 7, 7));
		pending_reqs.push_back(next_req());

		run_phase(1, 1, 60, 0, 0, 1'b0);
		run_phase(65535, 65535, 60, 82, 0, 1'b0);
		run_phase(1, 65535, 60, 0, 82, 1'b0);
		run_phase(65535, 1, 60, 37, 37, 1'b0);
		run_phase($urandom_range(1, 40), $urandom_range(1, 40), 80, 0, 0, 1'b1);
		run_phase($urandom_range(1, 40), $urandom_range(1, 40), 80, 82, 0, 1'b0);
		run_phase($urandom_range(1, 40), $urandom_range(1, 40), 80, 0, 82, 1'b0);
		run_phase($urandom_range(1, 300), $urandom_range(1, 300), 80, 37, 37, 1'b0);
		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#(LIMIT_TIME);
		$display("tb: errors");
		$finish;
	end

endmodule
